// File: hw/rtl/infix_to_postfix_converter_unit_macros.svh
// Assertion macros shared by the converter RTL.
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define IPC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define IPC_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define IPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: hw/rtl/ipc_pkg.sv
// Constants, types and character helpers for the infix to postfix converter.
package ipc_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int CHAR_W      = 8;
   localparam int PRIO_W      = 3;

   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
   localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_TILDE  = 8'h7E;
   localparam logic [CHAR_W-1:0] CH_NONE   = 8'h00;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_PAREN    = 2'd1,
      ST_INVALID  = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_EVAL   = 5'b00010,
      S_POP_OP = 5'b00100,
      S_POP_RP = 5'b01000,
      S_FLUSH  = 5'b10000
   } state_type;

   // operator precedence, zero for anything that is not an operator
   function automatic logic [PRIO_W-1:0] prio_of(logic [CHAR_W-1:0] c);
      logic [PRIO_W-1:0] p;
      case (c)
         "c", "s", "t", "C", "S", "T": p = 3'd5;
         "^", "$":                     p = 3'd4;
         "*", "/", "%":                p = 3'd3;
         "-":                          p = 3'd2;
         "+":                          p = 3'd1;
         default:                      p = 3'd0;
      endcase
      return p;
   endfunction

   function automatic logic is_operand(logic [CHAR_W-1:0] c);
      return c inside {["0":"9"], CH_DOT, CH_TILDE};
   endfunction

   function automatic logic is_blank(logic [CHAR_W-1:0] c);
      return c inside {CH_SPACE, [8'd9:8'd13]};
   endfunction

endpackage

// File: hw/rtl/ipc_stack_ram.sv
// Simple dual-port stack RAM with registered read and write-to-read bypass.
module ipc_stack_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // forward the word being written when the same entry is read
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/infix_to_postfix_converter_unit.sv
// Top level of the infix to postfix converter: sequencer, stack control, output register.
//
//  channel | dir | handshake             | tdata        | tuser              | tlast
//  req     | in  | req_tvalid/req_tready | [7:0] ch     | -                  | end_of_expr
//  rsp     | out | rsp_tvalid/rsp_tready | [7:0] out_ch | [0] has, [2:1] sts | last
//
// An item is accepted, then decoded; decode emits a passed-through character, the space before
// an operator, an error word or a skipped expression's terminator; each popped or flushed entry,
// the terminator after a flush, an operator push after its pops and a dropped open paren take a
// step each. Pops run one per cycle, unless the result stalls, on the registered stack RAM read.
// Reset clears the count, the open-paren count and the skip flag; stack entries
// are not cleared and there is no clearing pass.
// A stalled result holds the sequencer at its emitting step until the word is taken.
`include "infix_to_postfix_converter_unit_macros.svh"

module infix_to_postfix_converter_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] ch
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic [2:0] rsp_tuser,   // [0] has_char, [2:1] status
   output logic       rsp_tlast
);

   localparam logic [ipc_pkg::CNT_W-1:0] CNT_FULL = ipc_pkg::CNT_W'(ipc_pkg::STACK_DEPTH);
   localparam logic [ipc_pkg::CNT_W-1:0] CNT_ONE  = ipc_pkg::CNT_W'(1);

   ipc_pkg::state_type             state_ff, state_in;
   logic [ipc_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [ipc_pkg::CNT_W-1:0]      paren_ff, paren_in;
   logic                           skip_ff, skip_in;
   logic [ipc_pkg::CHAR_W-1:0]     ch_ff;
   logic                           end_ff;

   logic                           rsp_valid_ff;
   logic [ipc_pkg::CHAR_W-1:0]     rsp_char_ff;
   logic                           rsp_has_ff;
   ipc_pkg::status_type            rsp_status_ff;
   logic                           rsp_last_ff;

   logic                           req_fire;
   logic                           emit, emit_ok, emit_fire;
   logic [ipc_pkg::CHAR_W-1:0]     emit_char;
   logic                           emit_has;
   ipc_pkg::status_type            emit_status;
   logic                           emit_last;
   ipc_pkg::status_type            err_code;
   logic                           push;
   logic                           full;

   logic [ipc_pkg::CNT_W-1:0]      cnt_dec;
   logic [ipc_pkg::ADDR_W-1:0]     rd_addr;
   logic [ipc_pkg::CHAR_W-1:0]     top_data;
   logic [ipc_pkg::PRIO_W-1:0]     top_prio, ch_prio;

   assign req_tready = (state_ff == ipc_pkg::S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign emit_ok    = !rsp_valid_ff || rsp_tready;
   assign emit_fire  = emit && emit_ok;
   assign full       = (count_ff == CNT_FULL);
   assign top_prio   = ipc_pkg::prio_of(top_data);
   assign ch_prio    = ipc_pkg::prio_of(ch_ff);

   // read the entry that will be on top after this cycle's update
   assign cnt_dec = count_in - CNT_ONE;
   assign rd_addr = cnt_dec[ipc_pkg::ADDR_W-1:0];

   ipc_stack_ram #(
      .DEPTH (ipc_pkg::STACK_DEPTH),
      .WIDTH (ipc_pkg::CHAR_W)
   ) u_stack (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (count_ff[ipc_pkg::ADDR_W-1:0]),
      .wr_data (ch_ff),
      .rd_addr (rd_addr),
      .rd_data (top_data)
   );

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      paren_in    = paren_ff;
      skip_in     = skip_ff;
      emit        = 1'b0;
      emit_char   = ipc_pkg::CH_NONE;
      emit_has    = 1'b0;
      emit_status = ipc_pkg::ST_OK;
      emit_last   = 1'b0;
      err_code    = ipc_pkg::ST_OK;
      push        = 1'b0;
      case (state_ff)
         ipc_pkg::S_IDLE: begin
            if (req_fire) begin
               state_in = ipc_pkg::S_EVAL;
            end
         end
         ipc_pkg::S_EVAL: begin
            if (skip_ff) begin
               if (end_ff) begin
                  emit      = 1'b1;
                  emit_last = 1'b1;
                  if (emit_ok) begin
                     skip_in  = 1'b0;
                     state_in = ipc_pkg::S_IDLE;
                  end
               end else begin
                  state_in = ipc_pkg::S_IDLE;
               end
            end else if (ipc_pkg::is_operand(ch_ff)) begin
               emit      = 1'b1;
               emit_char = ch_ff;
               emit_has  = 1'b1;
               if (emit_ok) begin
                  state_in = end_ff ? ipc_pkg::S_FLUSH : ipc_pkg::S_IDLE;
               end
            end else if (ipc_pkg::is_blank(ch_ff)) begin
               state_in = end_ff ? ipc_pkg::S_FLUSH : ipc_pkg::S_IDLE;
            end else if (ch_prio != '0) begin
               // full with nothing to pop overflows before the space goes out
               if (full && (top_prio < ch_prio)) begin
                  err_code = ipc_pkg::ST_OVERFLOW;
               end else begin
                  emit      = 1'b1;
                  emit_char = ipc_pkg::CH_SPACE;
                  emit_has  = 1'b1;
                  if (emit_ok) begin
                     state_in = ipc_pkg::S_POP_OP;
                  end
               end
            end else if (ch_ff == ipc_pkg::CH_LPAREN) begin
               if (full) begin
                  err_code = ipc_pkg::ST_OVERFLOW;
               end else begin
                  push     = 1'b1;
                  count_in = count_ff + CNT_ONE;
                  paren_in = paren_ff + CNT_ONE;
                  state_in = end_ff ? ipc_pkg::S_FLUSH : ipc_pkg::S_IDLE;
               end
            end else if (ch_ff == ipc_pkg::CH_RPAREN) begin
               if (paren_ff == '0) begin
                  err_code = ipc_pkg::ST_PAREN;
               end else begin
                  state_in = ipc_pkg::S_POP_RP;
               end
            end else begin
               err_code = ipc_pkg::ST_INVALID;
            end
            if (err_code != ipc_pkg::ST_OK) begin
               emit        = 1'b1;
               emit_status = err_code;
               emit_last   = end_ff;
               if (emit_ok) begin
                  count_in = '0;
                  paren_in = '0;
                  skip_in  = !end_ff;
                  state_in = ipc_pkg::S_IDLE;
               end
            end
         end
         ipc_pkg::S_POP_OP: begin
            if ((count_ff != '0) && (top_prio >= ch_prio)) begin
               emit      = 1'b1;
               emit_char = top_data;
               emit_has  = 1'b1;
               if (emit_ok) begin
                  count_in = count_ff - CNT_ONE;
               end
            end else begin
               push     = 1'b1;
               count_in = count_ff + CNT_ONE;
               state_in = end_ff ? ipc_pkg::S_FLUSH : ipc_pkg::S_IDLE;
            end
         end
         ipc_pkg::S_POP_RP: begin
            if (top_data != ipc_pkg::CH_LPAREN) begin
               emit      = 1'b1;
               emit_char = top_data;
               emit_has  = 1'b1;
               if (emit_ok) begin
                  count_in = count_ff - CNT_ONE;
               end
            end else begin
               // drop the matching open paren
               count_in = count_ff - CNT_ONE;
               paren_in = paren_ff - CNT_ONE;
               state_in = end_ff ? ipc_pkg::S_FLUSH : ipc_pkg::S_IDLE;
            end
         end
         ipc_pkg::S_FLUSH: begin
            emit = 1'b1;
            if (count_ff != '0) begin
               emit_char = top_data;
               emit_has  = 1'b1;
               if (emit_ok) begin
                  count_in = count_ff - CNT_ONE;
                  if (top_data == ipc_pkg::CH_LPAREN) begin
                     paren_in = paren_ff - CNT_ONE;
                  end
               end
            end else begin
               emit_last = 1'b1;
               if (emit_ok) begin
                  state_in = ipc_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = ipc_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ipc_pkg::S_IDLE;
         count_ff <= '0;
         paren_ff <= '0;
         skip_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         paren_ff <= paren_in;
         skip_ff  <= skip_in;
      end
   end

   // hold the accepted word for the whole sequence
   always_ff @(posedge clock) begin
      if (req_fire) begin
         ch_ff  <= req_tdata;
         end_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_char_ff   <= emit_char;
         rsp_has_ff    <= emit_has;
         rsp_status_ff <= emit_status;
         rsp_last_ff   <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tuser  = {rsp_status_ff, rsp_has_ff};
   assign rsp_tlast  = rsp_last_ff;

   `IPC_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff <= CNT_FULL, "stack count above depth")
   `IPC_ASSERT_IMP(a_paren_le_count, clock, reset, 1'b1, paren_ff <= count_ff, "open parens exceed stack count")
   `IPC_ASSERT_IMP(a_skip_empty, clock, reset, skip_ff, count_ff == '0, "stack not empty while skipping")
   `IPC_ASSERT_NEXT(a_last_idle, clock, reset, emit_fire && emit_last, state_ff == ipc_pkg::S_IDLE, "final word did not end the sequence")

endmodule

// File: tb/infix_to_postfix_converter_unit_tb.sv
// Self-checking testbench for the infix to postfix converter unit.
module infix_to_postfix_converter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int ITEM_TARGET = 460;

   typedef struct {
      logic [7:0]          ch;
      logic                has;
      ipc_pkg::status_type sts;
      logic                last;
   } postfix_word_type;

   // Tracks the operator stack and holds the postfix words still owed by the block.
   class postfix_scoreboard;
      postfix_word_type expected_words[$];
      logic [7:0]       op_stack[ipc_pkg::STACK_DEPTH];
      int               depth;
      bit               skipping;
      int               mismatches;
      int               accepted_chars;

      function int rank(logic [7:0] c);
         logic [7:0] k;
         k = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
         case (k)
            "c", "s", "t": return 5;
            "^", "$":      return 4;
            "*", "/", "%": return 3;
            "-":           return 2;
            "+":           return 1;
            default:       return 0;
         endcase
      endfunction

      function void note_char(logic [7:0] c, logic eoe);
         postfix_word_type    words[$];
         ipc_pkg::status_type err;
         err = ipc_pkg::ST_OK;
         accepted_chars++;
         if (skipping) begin
            // swallow everything up to the end of the broken expression
            if (eoe) begin
               skipping = 1'b0;
               expected_words.push_back('{ipc_pkg::CH_NONE, 1'b0, ipc_pkg::ST_OK, 1'b1});
            end
            return;
         end
         if ((c >= "0" && c <= "9") || c == ipc_pkg::CH_DOT || c == ipc_pkg::CH_TILDE) begin
            words.push_back('{c, 1'b1, ipc_pkg::ST_OK, 1'b0});
         end else if (c == ipc_pkg::CH_SPACE || (c >= 8'd9 && c <= 8'd13)) begin
            // blanks produce nothing
         end else if (rank(c) > 0) begin
            words.push_back('{ipc_pkg::CH_SPACE, 1'b1, ipc_pkg::ST_OK, 1'b0});
            while (depth > 0 && rank(op_stack[depth-1]) >= rank(c)) begin
               words.push_back('{op_stack[depth-1], 1'b1, ipc_pkg::ST_OK, 1'b0});
               depth--;
            end
            if (depth >= ipc_pkg::STACK_DEPTH) begin
               err = ipc_pkg::ST_OVERFLOW;
            end else begin
               op_stack[depth] = c;
               depth++;
            end
         end else if (c == ipc_pkg::CH_LPAREN) begin
            if (depth >= ipc_pkg::STACK_DEPTH) begin
               err = ipc_pkg::ST_OVERFLOW;
            end else begin
               op_stack[depth] = c;
               depth++;
            end
         end else if (c == ipc_pkg::CH_RPAREN) begin
            while (depth > 0 && op_stack[depth-1] != ipc_pkg::CH_LPAREN) begin
               words.push_back('{op_stack[depth-1], 1'b1, ipc_pkg::ST_OK, 1'b0});
               depth--;
            end
            if (depth > 0) depth--;
            else err = ipc_pkg::ST_PAREN;
         end else begin
            err = ipc_pkg::ST_INVALID;
         end

         if (err != ipc_pkg::ST_OK) begin
            // the error word replaces everything this character produced
            depth = 0;
            skipping = !eoe;
            expected_words.push_back('{ipc_pkg::CH_NONE, 1'b0, err, eoe});
            return;
         end
         if (eoe) begin
            while (depth > 0) begin
               words.push_back('{op_stack[depth-1], 1'b1, ipc_pkg::ST_OK, 1'b0});
               depth--;
            end
            words.push_back('{ipc_pkg::CH_NONE, 1'b0, ipc_pkg::ST_OK, 1'b1});
         end
         foreach (words[i]) expected_words.push_back(words[i]);
      endfunction

      function void check_word(logic [7:0] d, logic [2:0] u, logic l);
         postfix_word_type want;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: ch=%02h has=%0b status=%0d last=%0b",
                        d, u[0], u[2:1], l);
            return;
         end
         want = expected_words.pop_front();
         if (d !== want.ch || u[0] !== want.has || u[2:1] !== 2'(want.sts) ||
             l !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected ch=%02h has=%0b status=%0d last=%0b, %s%02h %s",
                        want.ch, want.has, want.sts, want.last, "got ch=", d,
                        $sformatf("has=%0b status=%0d last=%0b", u[0], u[2:1], l));
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] ch
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [7:0] out_char
   logic [2:0] rsp_tuser;   // [0] has_char, [2:1] status
   logic       rsp_tlast;

   postfix_scoreboard sb = new();
   logic [7:0]        chars[$];
   bit                calm;
   int                rx_hold;
   int                cycle_count;

   infix_to_postfix_converter_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5ns clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // predict on every accepted character, then check every accepted word
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_char(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // receiver: random stalls, or a counted hold-off when one is requested
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rx_hold > 0) begin
            rsp_tready <= 1'b0;
            rx_hold--;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 13);
         end
      end
   end

   task automatic send_char(input logic [7:0] c, input logic eoe);
      while (!calm && $urandom_range(99) < 13) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= eoe;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_chars();
      for (int i = 0; i < chars.size(); i++) send_char(chars[i], i == chars.size() - 1);
   endtask

   task automatic send_text(input string s);
      chars = {};
      for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
      send_chars();
   endtask

   function automatic logic [7:0] pick_from(input string s);
      return s[$urandom_range(s.len() - 1)];
   endfunction

   function automatic logic [7:0] pick_blank();
      logic [7:0] b;
      b = 8'($urandom_range(8, 13));
      return (b == 8'd8) ? ipc_pkg::CH_SPACE : b;
   endfunction

   task automatic gen_well_formed();
      int open;
      int terms;
      chars = {};
      open = 0;
      terms = $urandom_range(1, 8);
      for (int i = 0; i < terms; i++) begin
         if ($urandom_range(5) == 0) begin
            chars.push_back(pick_from("cstCST"));
            chars.push_back(ipc_pkg::CH_LPAREN);
            open++;
         end
         while (open < 6 && $urandom_range(3) == 0) begin
            chars.push_back(ipc_pkg::CH_LPAREN);
            open++;
         end
         for (int k = $urandom_range(1, 3); k > 0; k--) chars.push_back(pick_from("0123456789.~"));
         if ($urandom_range(4) == 0) chars.push_back(pick_blank());
         while (open > 0 && $urandom_range(2) == 0) begin
            chars.push_back(ipc_pkg::CH_RPAREN);
            open--;
         end
         if (i != terms - 1) chars.push_back(pick_from("+-*/%^$cstCST"));
      end
      // leave a '(' open now and then so the flush has to emit it
      while (open > 0 && $urandom_range(5) != 0) begin
         chars.push_back(ipc_pkg::CH_RPAREN);
         open--;
      end
   endtask

   task automatic corrupt();
      int         pos;
      logic [7:0] bad;
      pos = $urandom_range(chars.size() - 1);
      case ($urandom_range(2))
         0:       bad = ipc_pkg::CH_RPAREN;
         1:       bad = pick_from("abxyzABXYZ=!?#&");
         default: bad = 8'($urandom_range(255));
      endcase
      chars.insert(pos, bad);
   endtask

   task automatic gen_noise();
      chars = {};
      for (int k = $urandom_range(1, 8); k > 0; k--) chars.push_back(8'($urandom_range(255)));
   endtask

   // nest deep enough to fill the stack, sometimes past it
   task automatic gen_deep();
      int n;
      chars = {};
      n = $urandom_range(26, 34);
      for (int k = 0; k < n; k++) begin
         chars.push_back(ipc_pkg::CH_LPAREN);
         if ($urandom_range(4) == 0) begin
            chars.push_back(pick_from("0123456789"));
            chars.push_back(pick_from("+-*/%^$cstCST"));
         end
      end
      chars.push_back(pick_from("0123456789.~"));
      for (int k = $urandom_range(n); k > 0; k--) chars.push_back(ipc_pkg::CH_RPAREN);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.expected_words.size() != 0) @(posedge clock);
   endtask

   initial begin
      int n_expr;
      int kind;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      calm = 1'b0;
      rx_hold = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every operator but 'c', operands, blanks, errors and an unmatched '('
      send_text("0+9-.*~/1%2^3$4");
      send_text("s(C\tt)S T\r");
      send_text(")");
      send_text("a1");
      send_text("(1");
      chars = {8'hFF};
      send_chars();
      chars = {8'h80, 8'h00};
      send_chars();

      // back up the result side while characters keep coming
      rx_hold = 300;
      gen_deep();
      send_chars();
      gen_deep();
      send_chars();
      wait_drained();

      n_expr = 0;
      while (sb.accepted_chars < ITEM_TARGET) begin
         calm = (n_expr >= 15 && n_expr < 27);
         kind = $urandom_range(99);
         if (kind < 60) begin
            gen_well_formed();
         end else if (kind < 74) begin
            gen_well_formed();
            corrupt();
         end else if (kind < 93) begin
            gen_noise();
         end else begin
            gen_deep();
         end
         send_chars();
         n_expr++;
      end
      calm = 1'b0;

      wait_drained();
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
